/* design/ldtb_pkg.sv */
package ldtb_pkg;

  localparam int MAX_LEVEL  = 100;
  localparam int COUNT_BITS = 24;
  localparam int BLINK_BITS = 18;

  // brightness*255/MAX_LEVEL as a multiply by a rounded-up reciprocal
  localparam int SCALE_SHIFT = 22;
  localparam logic [22:0] SCALE_RECIP = 23'((2**SCALE_SHIFT + MAX_LEVEL - 1) / MAX_LEVEL);

  localparam logic [2:0] REQ_POWER  = 3'd0;
  localparam logic [2:0] REQ_BRIGHT = 3'd1;
  localparam logic [2:0] REQ_TIMER  = 3'd2;
  localparam logic [2:0] REQ_BLINK  = 3'd3;
  localparam logic [2:0] REQ_TICK   = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_EXPIRY = 2'd2;
  localparam logic [1:0] ST_QUIET  = 2'd3;

  localparam int CHG_POWER  = 0;
  localparam int CHG_BRIGHT = 1;
  localparam int CHG_TIMER  = 2;
  localparam int CHG_BLINK  = 3;

  localparam logic [2:0] CFG_TIMER_SHORT  = 3'd0;
  localparam logic [2:0] CFG_TIMER_MEDIUM = 3'd1;
  localparam logic [2:0] CFG_TIMER_LONG   = 3'd2;
  localparam logic [2:0] CFG_BLINK_SLOW   = 3'd3;
  localparam logic [2:0] CFG_BLINK_MEDIUM = 3'd4;
  localparam logic [2:0] CFG_BLINK_FAST   = 3'd5;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [BLINK_BITS-1:0] blink_cnt_t;

  typedef struct packed {
    logic       power;
    logic [6:0] brightness;
    logic [1:0] timer_mode;
    logic [1:0] blink_mode;
    cnt_t       shutoff_count;
    blink_cnt_t blink_count;
    logic       blink_phase;
    logic [7:0] drive_level;
  } state_t;

  typedef struct packed {
    logic [21:0] timer_short_ms;
    logic [21:0] timer_medium_ms;
    logic [21:0] timer_long_ms;
    logic [15:0] blink_slow_ms;
    logic [15:0] blink_medium_ms;
    logic [15:0] blink_fast_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [7:0]        request_tag;
    logic              power_on;
    logic              is_delta;
    logic signed [7:0] set_value;
    logic [15:0]       elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] tag_echo;
    logic [3:0] changed_bits;
    logic [7:0] pwm_level;
    logic       light_power;
    logic [6:0] brightness_level;
    logic [1:0] timer_mode_now;
    logic [1:0] blink_mode_now;
  } result_t;

  function automatic logic [7:0] scale_level(input logic [6:0] level);
    logic [14:0] n;
    logic [37:0] p;
    n = {level, 8'b0} - {8'b0, level};
    p = {23'b0, n} * {15'b0, SCALE_RECIP};
    return p[SCALE_SHIFT+7:SCALE_SHIFT];
  endfunction

endpackage

/* design/ldtb_req_if.sv */
interface ldtb_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [7:0]        request_tag;
  logic              power_on;
  logic              is_delta;
  logic signed [7:0] set_value;
  logic [15:0]       elapsed_ms;

  modport source (
    output valid, req_type, request_tag, power_on, is_delta, set_value, elapsed_ms,
    input  ready
  );

  modport sink (
    input  valid, req_type, request_tag, power_on, is_delta, set_value, elapsed_ms,
    output ready
  );
endinterface

/* design/ldtb_rsp_if.sv */
interface ldtb_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] tag_echo;
  logic [3:0] changed_bits;
  logic [7:0] pwm_level;
  logic       light_power;
  logic [6:0] brightness_level;
  logic [1:0] timer_mode_now;
  logic [1:0] blink_mode_now;

  modport source (
    output valid, status, tag_echo, changed_bits, pwm_level, light_power,
           brightness_level, timer_mode_now, blink_mode_now,
    input  ready
  );

  modport sink (
    input  valid, status, tag_echo, changed_bits, pwm_level, light_power,
           brightness_level, timer_mode_now, blink_mode_now,
    output ready
  );
endinterface

/* design/ldtb_step.sv */
module ldtb_step
  import ldtb_pkg::*;
(
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  localparam logic signed [9:0] MAX_S = 10'(MAX_LEVEL);

  logic signed [9:0] value_s;
  logic signed [9:0] bri_sum;
  logic [6:0]        bri_next;
  logic              bri_chg;
  logic              bri_bad;
  logic signed [9:0] tm_tgt;
  logic signed [9:0] bl_tgt;
  logic              tm_bad;
  logic              bl_bad;
  logic              tm_same;
  logic              bl_same;
  logic [7:0]        scaled;
  logic              cnt_le0;
  logic              blink_le0;
  logic [1:0]        status;
  logic [3:0]        bits;
  state_t            nx;

  function automatic cnt_t timer_load(input logic [1:0] mode, input cfg_t c);
    cnt_t v;
    case (mode)
      2'd1:    v = COUNT_BITS'(c.timer_short_ms);
      2'd2:    v = COUNT_BITS'(c.timer_medium_ms);
      2'd3:    v = COUNT_BITS'(c.timer_long_ms);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic blink_cnt_t blink_load(input logic [1:0] mode, input cfg_t c);
    blink_cnt_t v;
    case (mode)
      2'd1:    v = BLINK_BITS'(c.blink_slow_ms);
      2'd2:    v = BLINK_BITS'(c.blink_medium_ms);
      default: v = BLINK_BITS'(c.blink_fast_ms);
    endcase
    return v;
  endfunction

  assign value_s = 10'(item.set_value);
  assign bri_sum = signed'({3'b000, st.brightness}) + value_s;

  always_comb begin
    bri_next = st.brightness;
    bri_chg  = 1'b0;
    bri_bad  = 1'b0;
    if (item.is_delta) begin
      if (bri_sum > MAX_S) begin
        if (st.brightness != 7'(MAX_LEVEL)) begin
          bri_next = 7'(MAX_LEVEL);
          bri_chg  = 1'b1;
        end
      end else if (bri_sum < 10'sd0) begin
        if (st.brightness != 7'd0) begin
          bri_next = 7'd0;
          bri_chg  = 1'b1;
        end
      end else begin
        bri_next = bri_sum[6:0];
        bri_chg  = 1'b1;
      end
    end else if (value_s < 10'sd0 || value_s > MAX_S) begin
      bri_bad = 1'b1;
    end else if (st.brightness != value_s[6:0]) begin
      bri_next = value_s[6:0];
      bri_chg  = 1'b1;
    end
  end

  // mode targets: step or absolute, legal range 0..3
  assign tm_tgt  = item.is_delta ? signed'({8'b0, st.timer_mode}) + value_s : value_s;
  assign bl_tgt  = item.is_delta ? signed'({8'b0, st.blink_mode}) + value_s : value_s;
  assign tm_bad  = tm_tgt < 10'sd0 || tm_tgt > 10'sd3;
  assign bl_bad  = bl_tgt < 10'sd0 || bl_tgt > 10'sd3;
  assign tm_same = !item.is_delta && tm_tgt[1:0] == st.timer_mode;
  assign bl_same = !item.is_delta && bl_tgt[1:0] == st.blink_mode;

  assign scaled = scale_level(item.req_type == REQ_BRIGHT ? bri_next : st.brightness);

  assign cnt_le0   = st.shutoff_count[COUNT_BITS-1] || st.shutoff_count == '0;
  assign blink_le0 = st.blink_count[BLINK_BITS-1] || st.blink_count == '0;

  always_comb begin
    nx     = st;
    status = ST_DONE;
    bits   = 4'b0;
    unique case (item.req_type)
      REQ_POWER: begin
        if (st.power != item.power_on) begin
          bits[CHG_POWER] = 1'b1;
          if (st.timer_mode != 2'd0) begin
            nx.timer_mode   = 2'd0;
            bits[CHG_TIMER] = 1'b1;
          end
          if (st.blink_mode != 2'd0) begin
            nx.blink_mode   = 2'd0;
            nx.blink_count  = '0;
            bits[CHG_BLINK] = 1'b1;
          end
          nx.power       = item.power_on;
          nx.drive_level = item.power_on ? scaled : 8'd0;
        end
      end
      REQ_BRIGHT: begin
        if (bri_bad) begin
          status = ST_RANGE;
        end else if (bri_chg) begin
          nx.brightness    = bri_next;
          bits[CHG_BRIGHT] = 1'b1;
          if (!st.power) begin
            nx.power        = 1'b1;
            bits[CHG_POWER] = 1'b1;
          end
          nx.drive_level = scaled;
        end
      end
      REQ_TIMER: begin
        if (tm_bad) begin
          status = ST_RANGE;
        end else if (!tm_same) begin
          nx.timer_mode    = tm_tgt[1:0];
          nx.shutoff_count = timer_load(tm_tgt[1:0], cfg);
          bits[CHG_TIMER]  = 1'b1;
          if (!st.power) begin
            nx.power        = 1'b1;
            nx.drive_level  = scaled;
            bits[CHG_POWER] = 1'b1;
          end
        end
      end
      REQ_BLINK: begin
        if (bl_bad) begin
          status = ST_RANGE;
        end else if (!bl_same) begin
          nx.blink_mode   = bl_tgt[1:0];
          nx.blink_phase  = 1'b1;
          bits[CHG_BLINK] = 1'b1;
          if (!st.power) begin
            nx.power        = 1'b1;
            nx.drive_level  = scaled;
            bits[CHG_POWER] = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        status = ST_QUIET;
        if (st.timer_mode != 2'd0) begin
          if (cnt_le0) begin
            nx.shutoff_count = '0;
            nx.timer_mode    = 2'd0;
            nx.power         = 1'b0;
            nx.drive_level   = 8'd0;
            bits[CHG_POWER]  = 1'b1;
            bits[CHG_TIMER]  = 1'b1;
            status           = ST_EXPIRY;
            if (st.blink_mode != 2'd0) begin
              nx.blink_mode   = 2'd0;
              nx.blink_count  = '0;
              bits[CHG_BLINK] = 1'b1;
            end
          end else begin
            nx.shutoff_count = st.shutoff_count - COUNT_BITS'(item.elapsed_ms);
          end
        end
        if (nx.blink_mode != 2'd0) begin
          if (blink_le0) begin
            nx.blink_phase = ~st.blink_phase;
            nx.drive_level = nx.blink_phase ? scaled : 8'd0;
            nx.blink_count = blink_load(nx.blink_mode, cfg);
          end else begin
            nx.blink_count = st.blink_count - BLINK_BITS'(item.elapsed_ms);
          end
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  assign st_next = nx;

  assign res.status           = status;
  assign res.tag_echo         = item.request_tag;
  assign res.changed_bits     = bits;
  assign res.pwm_level        = nx.drive_level;
  assign res.light_power      = nx.power;
  assign res.brightness_level = nx.brightness;
  assign res.timer_mode_now   = nx.timer_mode;
  assign res.blink_mode_now   = nx.blink_mode;

endmodule

/* design/led_dimmer_timer_blink_controller_core.sv */
// LED light controller: power, dimming, shutoff timer and blink control.
// req (sink): one beat per request or time tick; rsp (source): exactly one
// beat per request, in order, carrying status, changed bits and every
// current property. Both use valid/ready; a beat moves when both are high.
// cfg_we/cfg_index/cfg_data write the six timing registers (timer short,
// medium, long; blink slow, medium, fast); write only while the block is idle.
// A request taken into the input register is processed when the response
// register is free or draining. Throughput is one beat per cycle while rsp does not stall: all work
// for a beat sits between the input register and the response register, and
// the state updates in that same cycle, so back-to-back beats chain directly.
// The only multiplier is the brightness to PWM scaling.
// When rsp stalls, the response register holds, one more request is taken
// into the input register, and req.ready then drops until rsp drains.
// rst (synchronous) empties both registers, restores the property defaults
// (off, brightness 100, no timer, no blink) and the register defaults.
module led_dimmer_timer_blink_controller_core
  import ldtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ldtb_req_if.sink    req,
  ldtb_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   in_item;
  logic    in_vld;
  result_t res;
  result_t out_res;
  logic    out_vld;
  logic    process;

  assign process   = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || process;

  ldtb_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_item),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_short_ms  <= 22'd300000;
      cfg.timer_medium_ms <= 22'd600000;
      cfg.timer_long_ms   <= 22'd3600000;
      cfg.blink_slow_ms   <= 16'd1500;
      cfg.blink_medium_ms <= 16'd700;
      cfg.blink_fast_ms   <= 16'd300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMER_SHORT:  cfg.timer_short_ms  <= cfg_data;
        CFG_TIMER_MEDIUM: cfg.timer_medium_ms <= cfg_data;
        CFG_TIMER_LONG:   cfg.timer_long_ms   <= cfg_data;
        CFG_BLINK_SLOW:   cfg.blink_slow_ms   <= cfg_data[15:0];
        CFG_BLINK_MEDIUM: cfg.blink_medium_ms <= cfg_data[15:0];
        CFG_BLINK_FAST:   cfg.blink_fast_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.power         <= 1'b0;
      st.brightness    <= 7'(MAX_LEVEL);
      st.timer_mode    <= 2'd0;
      st.blink_mode    <= 2'd0;
      st.shutoff_count <= '0;
      st.blink_count   <= '0;
      st.blink_phase   <= 1'b0;
      st.drive_level   <= 8'd0;
    end else if (process) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.req_type    <= req.req_type;
      in_item.request_tag <= req.request_tag;
      in_item.power_on    <= req.power_on;
      in_item.is_delta    <= req.is_delta;
      in_item.set_value   <= req.set_value;
      in_item.elapsed_ms  <= req.elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (process) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_res <= res;
    end
  end

  assign rsp.valid            = out_vld;
  assign rsp.status           = out_res.status;
  assign rsp.tag_echo         = out_res.tag_echo;
  assign rsp.changed_bits     = out_res.changed_bits;
  assign rsp.pwm_level        = out_res.pwm_level;
  assign rsp.light_power      = out_res.light_power;
  assign rsp.brightness_level = out_res.brightness_level;
  assign rsp.timer_mode_now   = out_res.timer_mode_now;
  assign rsp.blink_mode_now   = out_res.blink_mode_now;

endmodule

/* tb/led_light_checker.sv */
`timescale 1ns / 1ps

module led_light_checker
  import ldtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ldtb_req_if         req,
  ldtb_rsp_if         rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [21:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          expiries,
  output int          rejects
);

  logic                         pwr;
  logic [6:0]                   level;
  logic [1:0]                   tmode;
  logic [1:0]                   bmode;
  logic signed [COUNT_BITS-1:0] shutoff;
  int                           blink_left;
  logic                         phase;
  logic [7:0]                   drive;
  cfg_t                         regs;

  result_t owed_results[$];

  function automatic logic [7:0] pwm_of(input logic [6:0] b);
    int p;
    p = (255 * int'(b)) / MAX_LEVEL;
    return 8'(p);
  endfunction

  function automatic result_t light_step(input item_t it);
    result_t    r;
    logic [3:0] chg;
    logic [1:0] st;
    logic [1:0] cur;
    int         v;
    int         sum;
    int         tgt;
    chg = '0;
    st  = ST_DONE;
    v   = int'($signed(it.set_value));
    case (it.req_type)
      REQ_POWER: begin
        if (pwr != it.power_on) begin
          if (tmode != 0) begin
            tmode = '0;
            chg[CHG_TIMER] = 1'b1;
          end
          if (bmode != 0) begin
            bmode = '0;
            blink_left = 0;
            chg[CHG_BLINK] = 1'b1;
          end
          chg[CHG_POWER] = 1'b1;
          pwr = it.power_on;
          drive = it.power_on ? pwm_of(level) : 8'd0;
        end
      end
      REQ_BRIGHT: begin
        if (it.is_delta) begin
          sum = int'(level) + v;
          if (sum > MAX_LEVEL) begin
            if (int'(level) != MAX_LEVEL) begin
              level = 7'(MAX_LEVEL);
              chg[CHG_BRIGHT] = 1'b1;
            end
          end else if (sum < 0) begin
            if (level != 0) begin
              level = '0;
              chg[CHG_BRIGHT] = 1'b1;
            end
          end else begin
            level = 7'(sum);
            chg[CHG_BRIGHT] = 1'b1;
          end
        end else if (v < 0 || v > MAX_LEVEL) begin
          st = ST_RANGE;
        end else if (int'(level) != v) begin
          level = 7'(v);
          chg[CHG_BRIGHT] = 1'b1;
        end
        if (chg != 0) begin
          if (!pwr) begin
            pwr = 1'b1;
            chg[CHG_POWER] = 1'b1;
          end
          drive = pwm_of(level);
        end
      end
      REQ_TIMER, REQ_BLINK: begin
        cur = (it.req_type == REQ_TIMER) ? tmode : bmode;
        tgt = it.is_delta ? int'(cur) + v : v;
        if (tgt < 0 || tgt > 3) begin
          st = ST_RANGE;
        end else if (it.is_delta || tgt != int'(cur)) begin
          if (it.req_type == REQ_TIMER) begin
            tmode = 2'(tgt);
            chg[CHG_TIMER] = 1'b1;
            case (tmode)
              2'd1: shutoff = COUNT_BITS'(regs.timer_short_ms);
              2'd2: shutoff = COUNT_BITS'(regs.timer_medium_ms);
              2'd3: shutoff = COUNT_BITS'(regs.timer_long_ms);
              default: shutoff = '0;
            endcase
          end else begin
            bmode = 2'(tgt);
            chg[CHG_BLINK] = 1'b1;
            phase = 1'b1;
          end
          if (!pwr) begin
            pwr = 1'b1;
            drive = pwm_of(level);
            chg[CHG_POWER] = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        st = ST_QUIET;
        if (tmode != 0) begin
          if (shutoff <= 0) begin
            shutoff = '0;
            tmode = '0;
            pwr = 1'b0;
            chg[CHG_POWER] = 1'b1;
            chg[CHG_TIMER] = 1'b1;
            if (bmode != 0) begin
              bmode = '0;
              blink_left = 0;
              chg[CHG_BLINK] = 1'b1;
            end
            drive = '0;
            st = ST_EXPIRY;
          end else begin
            shutoff = shutoff - COUNT_BITS'(it.elapsed_ms);
          end
        end
        if (bmode != 0) begin
          if (blink_left <= 0) begin
            phase = ~phase;
            drive = phase ? pwm_of(level) : 8'd0;
            case (bmode)
              2'd1: blink_left = int'(regs.blink_slow_ms);
              2'd2: blink_left = int'(regs.blink_medium_ms);
              default: blink_left = int'(regs.blink_fast_ms);
            endcase
          end else begin
            blink_left = blink_left - int'(it.elapsed_ms);
          end
        end
      end
      default: st = ST_RANGE;
    endcase
    r.status           = st;
    r.tag_echo         = it.request_tag;
    r.changed_bits     = chg;
    r.pwm_level        = drive;
    r.light_power      = pwr;
    r.brightness_level = level;
    r.timer_mode_now   = tmode;
    r.blink_mode_now   = bmode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    item_t   seen;
    result_t want;
    if (rst) begin
      pwr        = 1'b0;
      level      = 7'(MAX_LEVEL);
      tmode      = '0;
      bmode      = '0;
      shutoff    = '0;
      blink_left = 0;
      phase      = 1'b0;
      drive      = '0;
      regs.timer_short_ms  = 22'd300000;
      regs.timer_medium_ms = 22'd600000;
      regs.timer_long_ms   = 22'd3600000;
      regs.blink_slow_ms   = 16'd1500;
      regs.blink_medium_ms = 16'd700;
      regs.blink_fast_ms   = 16'd300;
      owed_results.delete();
      pending <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected beat, tag", 32'(rsp.tag_echo), 32'hFFFF_FFFF);
        end else begin
          want = owed_results.pop_front();
          checked++;
          if (want.status == ST_EXPIRY) expiries++;
          if (want.status == ST_RANGE) rejects++;
          compare_field("status", 32'(rsp.status), 32'(want.status));
          compare_field("tag_echo", 32'(rsp.tag_echo), 32'(want.tag_echo));
          compare_field("changed_bits", 32'(rsp.changed_bits), 32'(want.changed_bits));
          compare_field("pwm_level", 32'(rsp.pwm_level), 32'(want.pwm_level));
          compare_field("light_power", 32'(rsp.light_power), 32'(want.light_power));
          compare_field("brightness_level", 32'(rsp.brightness_level),
                        32'(want.brightness_level));
          compare_field("timer_mode_now", 32'(rsp.timer_mode_now),
                        32'(want.timer_mode_now));
          compare_field("blink_mode_now", 32'(rsp.blink_mode_now),
                        32'(want.blink_mode_now));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMER_SHORT:  regs.timer_short_ms  = cfg_data;
          CFG_TIMER_MEDIUM: regs.timer_medium_ms = cfg_data;
          CFG_TIMER_LONG:   regs.timer_long_ms   = cfg_data;
          CFG_BLINK_SLOW:   regs.blink_slow_ms   = cfg_data[15:0];
          CFG_BLINK_MEDIUM: regs.blink_medium_ms = cfg_data[15:0];
          CFG_BLINK_FAST:   regs.blink_fast_ms   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        seen.req_type    = req.req_type;
        seen.request_tag = req.request_tag;
        seen.power_on    = req.power_on;
        seen.is_delta    = req.is_delta;
        seen.set_value   = req.set_value;
        seen.elapsed_ms  = req.elapsed_ms;
        owed_results.push_back(light_step(seen));
      end
      pending <= owed_results.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ldtb_pkg::*;

  localparam int QUIET_LIMIT     = 5000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int PHASES          = 6;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [21:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int expiries;
  int rejects;
  int items_sent;

  ldtb_req_if req_ch ();
  ldtb_rsp_if rsp_ch ();

  led_dimmer_timer_blink_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  led_light_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .expiries   (expiries),
    .rejects    (rejects)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls: ready follows one of four randomly chosen styles, each held for a random run
  initial begin
    int style;
    int style_left;
    int beat_no;
    rsp_ch.ready = 1'b0;
    style = 0;
    style_left = 0;
    beat_no = 0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(50, 300);
      end
      style_left--;
      beat_no++;
      case (style)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom);
        2: rsp_ch.ready <= (beat_no % 8) < 5;
        default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d responses owed", QUIET_LIMIT, pending);
    $display("Regression FAIL");
    $finish;
  end

  task automatic send(input item_t it);
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= it.req_type;
    req_ch.request_tag <= it.request_tag;
    req_ch.power_on    <= it.power_on;
    req_ch.is_delta    <= it.is_delta;
    req_ch.set_value   <= it.set_value;
    req_ch.elapsed_ms  <= it.elapsed_ms;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  task automatic drain();
    idle(1);
    do @(posedge clk); while (pending != 0);
  endtask

  // blink registers keep only the low 16 bits; junk goes in the rest
  task automatic set_reg(input logic [2:0] idx, input logic [21:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    if (idx == CFG_BLINK_SLOW || idx == CFG_BLINK_MEDIUM || idx == CFG_BLINK_FAST)
      cfg_data <= {6'($urandom), val[15:0]};
    else
      cfg_data <= val;
  endtask

  task automatic load_phase(input int ph);
    logic [21:0] tmr[3];
    logic [15:0] blk[3];
    for (int i = 0; i < 3; i++) begin
      case (ph)
        1: begin
          tmr[i] = '0;
          blk[i] = '0;
        end
        2: begin
          tmr[i] = '1;
          blk[i] = '1;
        end
        5: begin
          tmr[i] = 22'($urandom);
          blk[i] = 16'($urandom);
        end
        default: begin
          tmr[i] = 22'($urandom_range(0, 20000));
          blk[i] = 16'($urandom_range(0, 2000));
        end
      endcase
    end
    set_reg(CFG_TIMER_SHORT, tmr[0]);
    set_reg(CFG_TIMER_MEDIUM, tmr[1]);
    set_reg(CFG_TIMER_LONG, tmr[2]);
    set_reg(CFG_BLINK_SLOW, 22'(blk[0]));
    set_reg(CFG_BLINK_MEDIUM, 22'(blk[1]));
    set_reg(CFG_BLINK_FAST, 22'(blk[2]));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic item_t mk(input logic [2:0] kind, input logic pwr_on,
                               input logic delta, input int v, input int ms);
    item_t it;
    it.req_type    = kind;
    it.request_tag = 8'($urandom);
    it.power_on    = pwr_on;
    it.is_delta    = delta;
    it.set_value   = 8'(v);
    it.elapsed_ms  = 16'(ms);
    return it;
  endfunction

  function automatic item_t rand_item(input int cap);
    item_t it;
    int    pick;
    it.request_tag = 8'($urandom);
    it.power_on    = 1'($urandom);
    it.is_delta    = 1'($urandom);
    it.set_value   = 8'($urandom);
    it.elapsed_ms  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      it.req_type = REQ_TICK;
      case ($urandom_range(0, 7))
        0: it.elapsed_ms = 16'($urandom);
        1: it.elapsed_ms = '0;
        default: it.elapsed_ms = 16'($urandom_range(0, cap));
      endcase
    end else if (pick < 44) begin
      it.req_type = REQ_POWER;
    end else if (pick < 64) begin
      it.req_type = REQ_BRIGHT;
      if ($urandom_range(0, 5) != 0)
        it.set_value = it.is_delta ? 8'($urandom_range(0, 40) - 20)
                                   : 8'($urandom_range(0, MAX_LEVEL));
    end else if (pick < 95) begin
      it.req_type = (pick < 80) ? REQ_TIMER : REQ_BLINK;
      if ($urandom_range(0, 5) != 0)
        it.set_value = it.is_delta ? 8'($urandom_range(0, 6) - 3)
                                   : 8'($urandom_range(0, 3));
    end else begin
      it.req_type = REQ_TICK + 3'($urandom_range(1, 3));
    end
    return it;
  endfunction

  initial begin
    int cap;
    int burst_left;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = '0;
    req_ch.request_tag = '0;
    req_ch.power_on    = 1'b0;
    req_ch.is_delta    = 1'b0;
    req_ch.set_value   = '0;
    req_ch.elapsed_ms  = '0;
    items_sent         = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send(mk(REQ_POWER, 1, 0, 0, 0));
    send(mk(REQ_POWER, 1, 0, 0, 0));
    send(mk(REQ_BRIGHT, 0, 0, 101, 0));
    send(mk(REQ_BRIGHT, 0, 0, -128, 0));
    send(mk(REQ_BRIGHT, 0, 0, 127, 0));
    send(mk(REQ_BRIGHT, 0, 0, 0, 0));
    send(mk(REQ_BRIGHT, 0, 1, 127, 0));
    send(mk(REQ_BRIGHT, 0, 1, 5, 0));
    send(mk(REQ_BRIGHT, 0, 1, -128, 0));
    send(mk(REQ_BRIGHT, 0, 1, -1, 0));
    send(mk(REQ_BRIGHT, 0, 1, 0, 0));
    send(mk(REQ_BRIGHT, 0, 0, MAX_LEVEL, 0));
    send(mk(REQ_POWER, 0, 0, 0, 0));
    send(mk(REQ_BRIGHT, 0, 1, -1, 0));
    send(mk(REQ_TIMER, 0, 0, 4, 0));
    send(mk(REQ_TIMER, 0, 0, -1, 0));
    send(mk(REQ_TIMER, 0, 1, 4, 0));
    send(mk(REQ_TIMER, 0, 0, 3, 0));
    send(mk(REQ_TIMER, 0, 1, 0, 0));
    send(mk(REQ_TIMER, 0, 1, -3, 0));
    send(mk(REQ_BLINK, 0, 0, 3, 0));
    send(mk(REQ_BLINK, 0, 0, 3, 0));
    send(mk(REQ_BLINK, 0, 1, -4, 0));
    send(mk(REQ_TICK, 0, 0, 0, 65535));
    send(mk(REQ_TICK, 0, 0, 0, 0));
    send(mk(REQ_TICK + 3'd3, 1, 1, -1, 65535));
    send(mk(REQ_POWER, 0, 0, 0, 0));
    send(mk(REQ_TIMER, 0, 0, 1, 0));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) load_phase(ph);
      case (ph)
        1: cap = 300;
        3, 4: cap = 3000;
        default: cap = 65535;
      endcase
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 6));
        end
        burst_left--;
        send(rand_item(cap));
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("%0d requests over %0d register settings (reset values, zeros, all ones, random)",
             items_sent, PHASES);
    $display("%0d responses checked: %0d shutoff expiries, %0d rejected requests",
             checked, expiries, rejects);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ldtb_pkg.sv
design/ldtb_req_if.sv
design/ldtb_rsp_if.sv
design/ldtb_step.sv
design/led_dimmer_timer_blink_controller_core.sv
tb/led_light_checker.sv
tb/tb.sv
